FILE: sv/fire_effect_propagation_defines.svh
// Assertion helpers shared by the fire effect RTL.
// Each expects signals named clk and rst in the scope of use.
`ifndef FIRE_EFFECT_PROPAGATION_DEFINES_SVH
`define FIRE_EFFECT_PROPAGATION_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define FEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define FEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/fep_pkg.sv
package fep_pkg;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 12;
  localparam int DECAY_W = 2;
  localparam int LEVEL_W = 6;
  localparam int COLOUR_W = 8;

  localparam logic [LEVEL_W-1:0] SOURCE_RESET = 6'd36;
  localparam logic [LEVEL_W-1:0] PALETTE_TOP  = 6'd36;

  typedef enum logic [CMD_W-1:0] {
    CMD_IGNITE    = 2'd0,
    CMD_PROPAGATE = 2'd1,
    CMD_READ      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IGNITE,
    ST_PROP_WR,
    ST_READ_OUT
  } state_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } rgb_t;

  localparam rgb_t PALETTE [37] = '{
    '{8'd7, 8'd7, 8'd7},       '{8'd31, 8'd7, 8'd7},
    '{8'd47, 8'd15, 8'd7},     '{8'd71, 8'd15, 8'd7},
    '{8'd87, 8'd23, 8'd7},     '{8'd103, 8'd31, 8'd7},
    '{8'd119, 8'd31, 8'd7},    '{8'd143, 8'd39, 8'd7},
    '{8'd159, 8'd47, 8'd7},    '{8'd175, 8'd63, 8'd7},
    '{8'd191, 8'd71, 8'd7},    '{8'd199, 8'd71, 8'd7},
    '{8'd223, 8'd79, 8'd7},    '{8'd223, 8'd87, 8'd7},
    '{8'd223, 8'd87, 8'd7},    '{8'd215, 8'd95, 8'd7},
    '{8'd215, 8'd95, 8'd7},    '{8'd215, 8'd103, 8'd15},
    '{8'd207, 8'd111, 8'd15},  '{8'd207, 8'd119, 8'd15},
    '{8'd207, 8'd127, 8'd15},  '{8'd207, 8'd135, 8'd23},
    '{8'd199, 8'd135, 8'd23},  '{8'd199, 8'd143, 8'd23},
    '{8'd199, 8'd151, 8'd31},  '{8'd191, 8'd159, 8'd31},
    '{8'd191, 8'd159, 8'd31},  '{8'd191, 8'd167, 8'd39},
    '{8'd191, 8'd167, 8'd39},  '{8'd191, 8'd175, 8'd47},
    '{8'd183, 8'd175, 8'd47},  '{8'd183, 8'd183, 8'd47},
    '{8'd183, 8'd183, 8'd55},  '{8'd207, 8'd207, 8'd111},
    '{8'd223, 8'd223, 8'd159}, '{8'd239, 8'd239, 8'd199},
    '{8'd255, 8'd255, 8'd255}
  };

  // Levels above the top of the palette show as white.
  function automatic rgb_t colour_of(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W-1:0] entry;
    entry = (level > PALETTE_TOP) ? PALETTE_TOP : level;
    return PALETTE[entry];
  endfunction

endpackage

FILE: sv/fep_in_if.sv
interface fep_in_if;
  import fep_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] pixel_index;
  logic [DECAY_W-1:0] decay;

  modport source (output valid, cmd, pixel_index, decay, input ready);
  modport sink (input valid, cmd, pixel_index, decay, output ready);
endinterface

FILE: sv/fep_out_if.sv
interface fep_out_if;
  import fep_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  intensity;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;

  modport source (output valid, intensity, red, green, blue, input ready);
  modport sink (input valid, intensity, red, green, blue, output ready);
endinterface

FILE: sv/fep_ram.sv
module fep_ram #(
  parameter int DATA_W = 6,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/fire_effect_propagation.sv
// Channel   Dir  Payload                              Transfer
// in_ch     in   cmd, pixel_index, decay              valid && ready
// out_ch    out  intensity, red, green, blue          valid && ready
// cfg       in   cfg_data (source intensity)          cfg_we
//
// After reset a clearing pass zeroes every pixel of the store, with
// in_ch.ready low; configuration writes are taken throughout.
// Propagate reads in ST_IDLE, then writes in ST_PROP_WR (single pixel RAM
// port pair); a bottom-row propagate and the unused command stay in ST_IDLE.
// Ignite writes the source intensity to the bottom row, one pixel per cycle.
// Read waits in ST_READ_OUT while the output register still holds an
// untaken result; once loaded, the output register lets the next item in.
`include "fire_effect_propagation_defines.svh"

module fire_effect_propagation #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fep_pkg::LEVEL_W-1:0] cfg_data,
  fep_in_if.sink                     in_ch,
  fep_out_if.source                  out_ch
);
  import fep_pkg::*;

  localparam int PIXELS = WIDTH * HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam int COL_W  = $clog2(WIDTH);
  localparam int SUM_W  = $clog2(PIXELS + 4352);
  localparam logic [ADDR_W-1:0] ROW_BASE  = ADDR_W'(PIXELS - WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(WIDTH - 1);

  state_t state, state_next;

  logic [LEVEL_W-1:0] source_intensity;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [COL_W-1:0]   col_cnt;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_ok;
  logic [DECAY_W-1:0] decay_q;
  logic               in_range;

  logic               out_valid;
  logic [LEVEL_W-1:0] out_intensity;
  rgb_t               out_rgb;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [LEVEL_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [LEVEL_W-1:0] ram_rdata;

  logic               accept;
  cmd_t               cmd;
  logic [SUM_W-1:0]   below;
  logic               below_ok;
  logic               idx_ok;
  logic               out_free;
  logic [LEVEL_W-1:0] decayed;
  logic [LEVEL_W-1:0] read_level;

  assign cmd      = cmd_t'(in_ch.cmd);
  assign accept   = in_ch.valid && in_ch.ready;
  assign below    = SUM_W'(in_ch.pixel_index) + SUM_W'(WIDTH);
  assign below_ok = below < SUM_W'(PIXELS);
  assign idx_ok   = SUM_W'(in_ch.pixel_index) < SUM_W'(PIXELS);
  assign out_free = !out_valid || out_ch.ready;

  assign decayed = (ram_rdata >= LEVEL_W'(decay_q)) ?
                   ram_rdata - LEVEL_W'(decay_q) : '0;
  assign read_level = in_range ? ram_rdata : '0;

  fep_ram #(
    .DATA_W (LEVEL_W),
    .DEPTH  (PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_IGNITE:    state_next = ST_IGNITE;
            CMD_PROPAGATE: state_next = below_ok ? ST_PROP_WR : ST_IDLE;
            CMD_READ:      state_next = ST_READ_OUT;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_IGNITE: begin
        if (col_cnt == LAST_COL) begin
          state_next = ST_IDLE;
        end
      end
      ST_PROP_WR:  state_next = ST_IDLE;
      ST_READ_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ADDR_W'(in_ch.pixel_index);
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_re      = in_ch.valid;
        if (cmd == CMD_PROPAGATE) begin
          ram_raddr = below[ADDR_W-1:0];
        end
      end
      ST_IGNITE: begin
        ram_we    = 1'b1;
        ram_waddr = ROW_BASE + ADDR_W'(col_cnt);
        ram_wdata = source_intensity;
      end
      ST_PROP_WR: begin
        ram_we    = wr_ok;
        ram_waddr = wr_addr;
        ram_wdata = decayed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      source_intensity <= SOURCE_RESET;
      clr_cnt          <= '0;
      col_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        source_intensity <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_IGNITE) begin
        col_cnt <= col_cnt + 1'b1;
      end else begin
        col_cnt <= '0;
      end
      if (state == ST_READ_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item fields held for the propagate write and the read; read result loaded.
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr  <= ADDR_W'(in_ch.pixel_index - INDEX_W'(in_ch.decay));
      wr_ok    <= in_ch.pixel_index >= INDEX_W'(in_ch.decay);
      decay_q  <= in_ch.decay;
      in_range <= idx_ok;
    end
    if (state == ST_READ_OUT && out_free) begin
      out_intensity <= read_level;
      out_rgb       <= colour_of(read_level);
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.intensity = out_intensity;
  assign out_ch.red       = out_rgb.red;
  assign out_ch.green     = out_rgb.green;
  assign out_ch.blue      = out_rgb.blue;

  `FEP_ASSERT_NOW(a_no_write_when_ready, in_ch.ready, !ram_we, "store written while taking items")
  `FEP_ASSERT_NOW(a_ignite_bottom_row, state == ST_IGNITE, ram_waddr >= ROW_BASE, "ignite outside bottom row")
  `FEP_ASSERT_NEXT(a_read_loads_output, state == ST_READ_OUT && out_free, out_valid && state == ST_IDLE, "read result not loaded")
  `FEP_ASSERT_NEXT(a_bottom_row_skip, accept && cmd == CMD_PROPAGATE && !below_ok, state == ST_IDLE, "bottom-row propagate not skipped")

endmodule
